// ===== design/b64_pkg.sv =====
// Shared types, constants and the character lookup for the base64 stream encoder.
// No dependencies.
package b64_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0] PAD_CHAR  = 7'h3D;
    localparam logic [5:0] SIX_MASK  = 6'h3F;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_word;

    typedef struct packed {
        logic [6:0] out_char;
        logic       final_char;
    } t_out_word;

    typedef enum logic [1:0] {
        GRP_0 = 2'd0,
        GRP_1 = 2'd1,
        GRP_2 = 2'd2
    } t_grp;

    typedef struct packed {
        logic       pad;
        logic [5:0] six;
    } t_sym;

    typedef struct packed {
        t_sym [3:0] sym;
        logic [1:0] last_idx;
        logic       final_byte;
    } t_job;

    function automatic logic [6:0] b64_char(input logic [5:0] six);
        logic [6:0] ch;
        priority if (six < 6'd26) begin
            ch = 7'(six) + 7'd65;
        end else if (six < 6'd52) begin
            ch = 7'(six) + 7'd71;
        end else if (six < 6'd62) begin
            ch = 7'(six) - 7'd4;
        end else if (six == 6'd62) begin
            ch = 7'h2B;
        end else begin
            ch = 7'h2F;
        end
        return ch;
    endfunction

endpackage

// ===== design/b64_front.sv =====
// Front end: accepts input words, tracks the three-byte group and builds a job.
// Depends on b64_pkg.
module b64_front
    import b64_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_word i_in_word,
    input  logic     i_q_full,
    output logic     o_push,
    output t_job     o_job
);

    t_grp       r_grp, n_grp;
    logic [3:0] r_left, n_left;
    logic [7:0] b;
    logic       fin;

    assign b          = i_in_word.data_byte;
    assign fin        = i_in_word.final_byte;
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        n_grp  = r_grp;
        n_left = r_left;
        if (o_push) begin
            unique case (r_grp)
                GRP_1: begin
                    n_grp  = GRP_2;
                    n_left = b[3:0];
                end
                GRP_2: begin
                    n_grp  = GRP_0;
                    n_left = 4'd0;
                end
                default: begin
                    n_grp  = GRP_1;
                    n_left = {2'b00, b[1:0]};
                end
            endcase
            if (fin) begin
                n_grp  = GRP_0;
                n_left = 4'd0;
            end
        end
    end

    always_comb begin
        o_job            = '0;
        o_job.final_byte = fin;
        unique case (r_grp)
            GRP_1: begin
                o_job.sym[0].six = {r_left[1:0], b[7:4]};
                if (fin) begin
                    o_job.sym[1].six = {b[3:0], 2'b00};
                    o_job.sym[2].pad = 1'b1;
                    o_job.last_idx   = 2'd2;
                end
            end
            GRP_2: begin
                o_job.sym[0].six = {r_left, b[7:6]};
                o_job.sym[1].six = b[5:0] & SIX_MASK;
                o_job.last_idx   = 2'd1;
            end
            default: begin
                o_job.sym[0].six = b[7:2];
                if (fin) begin
                    o_job.sym[1].six = {b[1:0], 4'b0000};
                    o_job.sym[2].pad = 1'b1;
                    o_job.sym[3].pad = 1'b1;
                    o_job.last_idx   = 2'd3;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp  <= GRP_0;
            r_left <= 4'd0;
        end else begin
            r_grp  <= n_grp;
            r_left <= n_left;
        end
    end

endmodule

// ===== design/b64_queue.sv =====
// Short job queue between the front and back ends.
// Depends on b64_pkg.
module b64_queue
    import b64_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_CW-1:0] r_cnt;

    assign o_full  = (r_cnt == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + QUEUE_CW'(i_push) - QUEUE_CW'(i_pop);
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("push lost");
`endif

endmodule

// ===== design/b64_back.sv =====
// Back end: walks the symbols of each job and drives the registered output word.
// Depends on b64_pkg.
module b64_back
    import b64_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic [1:0] r_idx;
    logic       r_out_valid;
    t_out_word  r_out;
    logic       load, emit, at_end;
    t_sym       sym;

    assign load        = !r_out_valid || i_out_ready;
    assign emit        = load && i_q_valid;
    assign at_end      = (r_idx == i_job.last_idx);
    assign o_pop       = emit && at_end;
    assign sym         = i_job.sym[r_idx];
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= i_q_valid;
            end
            if (emit) begin
                r_idx <= at_end ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.out_char   <= sym.pad ? PAD_CHAR : b64_char(sym.six);
            r_out.final_char <= i_job.final_byte && at_end;
        end
    end

`ifndef SYNTHESIS
    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> r_idx <= i_job.last_idx)
        else $error("symbol index past end of job");
    a_final_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && !at_end |=> !r_out.final_char)
        else $error("final character flagged mid job");
    a_idx_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_idx == 2'd0)
        else $error("index not cleared after job");
`endif

endmodule

// ===== design/base64_stream_encoder.sv =====
// Streaming base64 encoder top level: front end, job queue and back end.
// Depends on b64_pkg, b64_front, b64_queue and b64_back.
//
// Takes one message byte per input word and emits one base64 character per output
// word (standard alphabet, '=' padding, last character flagged). A byte yields one
// or two characters, up to four on the last byte of a message; the output port
// delivers one character per cycle while i_out_ready is high. A byte's job is
// registered in the job queue, and its first character then in the output word
// register. A two-entry job queue decouples input from output, so bytes keep
// being taken while characters wait, until the queue is full.
module base64_stream_encoder
    import b64_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic q_full, q_push, q_valid, q_pop;
    t_job push_job, head_job;

    b64_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_job      (push_job)
    );

    b64_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (q_pop)
    );

    b64_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_job       (head_job),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
